@@ hw/rtl/coverage_alpha_blend_canvas_core_macros.svh @@
// Assertion macros shared by the checker of the canvas compositing core.
// Each macro samples on clk and is switched off while arst_n is low.
`ifndef COVERAGE_ALPHA_BLEND_CANVAS_CORE_MACROS_SVH
`define COVERAGE_ALPHA_BLEND_CANVAS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CABC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("canvas core check failed");

// The consequent must hold in the cycle after the antecedent.
`define CABC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("canvas core check failed");

`endif

@@ hw/rtl/cabc_pkg.sv @@
// Shared types and constants of the canvas compositing core.
// Used by the register block, the controller, the datapath and the top level.
`default_nettype none

package cabc_pkg;

	// Default depth of the canvas store in 32-bit words.
	localparam int unsigned CANVAS_WORDS_DEF = 524288;

	// Width of the linear store index before the depth check.
	localparam int unsigned LIN_W = 25;

	// Request kinds carried in the input tuser.
	localparam logic [1:0] REQ_BLEND = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_TOP    = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	// Canvas rectangle as held in the register block.
	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [12:0] width;
		logic [12:0] height;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic take;
		logic locate;
		logic read;
		logic src;
		logic mix;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/coverage_alpha_blend_canvas_core.sv @@
// Items are taken one at a time: the next input transfer waits for the locate, store
// read, source alpha, blend and write-back steps on the single store port. A read result
// is loaded into the output register in the final step, which waits for a free output register.
// Reset: asynchronous, active low; a clearing pass then zeroes every store word, one word a
// cycle, with no input transfer taken (register writes are).
`default_nettype none

module coverage_alpha_blend_canvas_core #(
	parameter int unsigned CANVAS_WORDS = cabc_pkg::CANVAS_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// From bit 0: pos_x[11:0], pos_y[23:12], coverage[31:24], color_rgba[63:32].
	input  wire logic [63:0] s_tdata,
	// Bits 1:0: req_type.
	input  wire logic [1:0]  s_tuser,
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// Bits 31:0: pixel_word.
	output logic      [31:0] m_tdata,
	// Bit 0: out_of_range.
	output logic      [0:0]  m_tuser
);
	import cabc_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Canvas rectangle registers.
	cabc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	cabc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Store and arithmetic.
	cabc_dp #(
		.CANVAS_WORDS (CANVAS_WORDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg      (cfg),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ hw/rtl/cabc_regs.sv @@
// APB-style register block holding the canvas rectangle.
// Depends on cabc_pkg for the register indexes and the cfg_t type.
`default_nettype none

module cabc_regs (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [3:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	output cabc_pkg::cfg_t        cfg
);
	import cabc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left   <= 12'd0;
			cfg_q.top    <= 12'd0;
			cfg_q.width  <= 13'd1;
			cfg_q.height <= 13'd1;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LEFT:   cfg_q.left   <= pwdata[11:0];
				REG_TOP:    cfg_q.top    <= pwdata[11:0];
				REG_WIDTH:  cfg_q.width  <= pwdata[12:0];
				REG_HEIGHT: cfg_q.height <= pwdata[12:0];
			endcase
		end
	end

	// Read-back multiplexer, zero-extended to the bus width.
	always_comb begin
		unique case (paddr[3:2])
			REG_LEFT:   prdata = {20'd0, cfg_q.left};
			REG_TOP:    prdata = {20'd0, cfg_q.top};
			REG_WIDTH:  prdata = {19'd0, cfg_q.width};
			REG_HEIGHT: prdata = {19'd0, cfg_q.height};
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/cabc_dp.sv @@
// Datapath of the canvas compositing core: canvas store, address and
// blend arithmetic, output register. Depends on cabc_pkg.
`default_nettype none

module cabc_dp #(
	parameter int unsigned CANVAS_WORDS = cabc_pkg::CANVAS_WORDS_DEF,
	localparam int unsigned AW = $clog2(CANVAS_WORDS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cabc_pkg::cmd_t   cmd,
	output cabc_pkg::sts_t        sts,
	input  wire cabc_pkg::cfg_t   cfg,
	input  wire logic [63:0]      s_tdata,
	input  wire logic [1:0]       s_tuser,
	input  wire logic             m_tready,
	output logic                  m_tvalid,
	output logic      [31:0]      m_tdata,
	output logic      [0:0]       m_tuser
);
	import cabc_pkg::*;

	// Canvas store.
	logic [31:0] mem [CANVAS_WORDS];

	logic [AW-1:0]    cnt_q;
	logic [1:0]       req_q;
	logic [11:0]      x_q;
	logic [11:0]      y_q;
	logic [7:0]       cov_q;
	logic [31:0]      col_q;
	logic [LIN_W-1:0] lin_q;
	logic             rng_q;
	logic             in_q;
	logic [31:0]      rd_q;
	logic [7:0]       src_q;
	logic [31:0]      mix_q;
	logic             out_valid_q;
	logic [31:0]      out_pix_q;
	logic             out_oor_q;

	logic [12:0]      dx;
	logic [12:0]      dy;
	logic             rng;
	logic [LIN_W-1:0] lin;
	logic [15:0]      src_prod;
	logic [7:0]       inv;
	logic [15:0]      a_prod;
	logic [16:0]      r_sum;
	logic [16:0]      g_sum;
	logic [16:0]      b_sum;
	logic [7:0]       oa;
	logic             we;
	logic [AW-1:0]    wa;
	logic [31:0]      wd;
	logic             ld_out;

	// Offsets into the rectangle and the linear index.
	always_comb begin
		dx  = {1'b0, x_q} - {1'b0, cfg.left};
		dy  = {1'b0, y_q} - {1'b0, cfg.top};
		rng = (x_q >= cfg.left) && (y_q >= cfg.top) &&
		      ({1'b0, dx[11:0]} < cfg.width) && ({1'b0, dy[11:0]} < cfg.height);
		lin = LIN_W'(dy[11:0]) * LIN_W'(cfg.width) + LIN_W'(dx[11:0]);
	end

	// Source alpha from coverage and inverted colour alpha.
	assign src_prod = 16'(cov_q) * 16'(8'hff - col_q[7:0]);

	// Channel blends against the destination pixel.
	always_comb begin
		inv    = 8'hff - src_q;
		a_prod = 16'(rd_q[31:24]) * 16'(inv);
		oa     = src_q + a_prod[15:8];
		r_sum  = 17'(16'(col_q[31:24]) * 16'(src_q)) + 17'(16'(rd_q[23:16]) * 16'(inv));
		g_sum  = 17'(16'(col_q[23:16]) * 16'(src_q)) + 17'(16'(rd_q[15:8]) * 16'(inv));
		b_sum  = 17'(16'(col_q[15:8]) * 16'(src_q)) + 17'(16'(rd_q[7:0]) * 16'(inv));
	end

	// Store write: the clearing pass, or the write-back of a blend or clear.
	always_comb begin
		we = cmd.clr_step |
		     (cmd.finish & in_q & ((req_q == REQ_BLEND) || (req_q == REQ_CLEAR)));
		wa = cmd.clr_step ? cnt_q : lin_q[AW-1:0];
		wd = (!cmd.clr_step && (req_q == REQ_BLEND)) ? mix_q : 32'd0;
	end

	assign ld_out = cmd.finish & (req_q == REQ_READ);

	// Store port: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.read) begin
			rd_q <= mem[lin_q[AW-1:0]];
		end
	end

	// Clearing pass address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Item registers and arithmetic stages.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= s_tuser;
			x_q   <= s_tdata[11:0];
			y_q   <= s_tdata[23:12];
			cov_q <= s_tdata[31:24];
			col_q <= s_tdata[63:32];
		end
		if (cmd.locate) begin
			lin_q <= lin;
			rng_q <= rng;
		end
		if (cmd.read) begin
			in_q <= rng_q && (lin_q < LIN_W'(CANVAS_WORDS));
		end
		if (cmd.src) begin
			src_q <= src_prod[15:8];
		end
		if (cmd.mix) begin
			mix_q <= {oa, r_sum[15:8], g_sum[15:8], b_sum[15:8]};
		end
	end

	// Output register towards the result stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_pix_q <= in_q ? rd_q : 32'd0;
			out_oor_q <= ~in_q;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_pix_q;
	assign m_tuser      = out_oor_q;

	assign sts.clr_done = (cnt_q == AW'(CANVAS_WORDS - 1));
	assign sts.is_read  = (req_q == REQ_READ);
	assign sts.out_free = ~out_valid_q | m_tready;

endmodule

`default_nettype wire

@@ hw/rtl/cabc_ctrl.sv @@
// Controller of the canvas compositing core: clearing pass and item sequence.
// Depends on cabc_pkg for the command and status types.
`default_nettype none

module cabc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output cabc_pkg::cmd_t        cmd,
	input  wire cabc_pkg::sts_t   sts
);
	import cabc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOC,
		ST_RD,
		ST_SRC,
		ST_MIX,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   rdy_q;
	logic   fin_go;

	// A read waits in the final step until the output register is free.
	assign fin_go = ~sts.is_read | sts.out_free;

	// State and registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rdy_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && rdy_q) begin
						state_q <= ST_LOC;
						rdy_q   <= 1'b0;
					end
				end
				ST_LOC: state_q <= ST_RD;
				ST_RD:  state_q <= ST_SRC;
				ST_SRC: state_q <= ST_MIX;
				ST_MIX: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					rdy_q   <= 1'b0;
				end
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.take     = (state_q == ST_IDLE) && rdy_q && s_tvalid;
		cmd.locate   = (state_q == ST_LOC);
		cmd.read     = (state_q == ST_RD);
		cmd.src      = (state_q == ST_SRC);
		cmd.mix      = (state_q == ST_MIX);
		cmd.finish   = (state_q == ST_FIN) && fin_go;
	end

	assign s_tready = rdy_q;

endmodule

`default_nettype wire

@@ hw/rtl/cabc_chk.sv @@
// Port-level checker of the canvas compositing core, bound to the top level.
// Depends on the assertion macros in coverage_alpha_blend_canvas_core_macros.svh.
`default_nettype none
`include "coverage_alpha_blend_canvas_core_macros.svh"

module cabc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// A stalled result keeps its contents.
	`CABC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Items are taken one at a time: ready drops after each input transfer.
	`CABC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

	// A position outside the canvas reads as a zero pixel.
	`CABC_ASSERT_SAME(a_oor_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0)

endmodule

bind coverage_alpha_blend_canvas_core cabc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/coverage_alpha_blend_canvas_core_tb.sv @@
// Self-checking bench for the canvas compositing core: blend, read and clear transfers are
// driven against a mirrored canvas and rectangle, and every read result is checked in order.
// Depends on cabc_pkg and coverage_alpha_blend_canvas_core.
`timescale 1ns / 100ps

module coverage_alpha_blend_canvas_core_tb;
	import cabc_pkg::*;

	// Request code that the core must ignore.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Cycles allowed after the last expected result for a blend still in flight.
	localparam int unsigned SETTLE_CYCLES = 16;
	// Random transfers per phase and number of random phases.
	localparam int unsigned PHASE_ITEMS = 150;
	localparam int unsigned PHASE_COUNT = 7;
	// Length of the receiver hold-off that backs the pipeline up.
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		logic [31:0] pixel;
		logic        outside;
	} pixel_result_t;

	// Mirror of the canvas store and rectangle; predicts read results.
	class canvas_scoreboard;
		cfg_t            canvas_cfg;
		logic [31:0]     pixel_mirror [int unsigned];
		pixel_result_t   awaited_pixels [$];
		int unsigned     errors;

		function new();
			canvas_cfg.left   = '0;
			canvas_cfg.top    = '0;
			canvas_cfg.width  = 13'd1;
			canvas_cfg.height = 13'd1;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_LEFT:   canvas_cfg.left   = value[11:0];
				REG_TOP:    canvas_cfg.top    = value[11:0];
				REG_WIDTH:  canvas_cfg.width  = value[12:0];
				REG_HEIGHT: canvas_cfg.height = value[12:0];
				default: ;
			endcase
		endfunction

		// Maps an absolute position to a store word; false when outside the canvas or store.
		function bit locate(logic [11:0] x, logic [11:0] y, output int unsigned idx);
			int unsigned dx;
			int unsigned dy;
			longint unsigned lin;
			idx = 0;
			if (x < canvas_cfg.left || y < canvas_cfg.top)
				return 1'b0;
			dx = x - canvas_cfg.left;
			dy = y - canvas_cfg.top;
			if (dx >= canvas_cfg.width || dy >= canvas_cfg.height)
				return 1'b0;
			lin = dy;
			lin = lin * canvas_cfg.width + dx;
			if (lin >= CANVAS_WORDS_DEF)
				return 1'b0;
			idx = int'(lin);
			return 1'b1;
		endfunction

		function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] src,
				logic [7:0] inv);
			logic [16:0] acc;
			acc = 17'(s) * 17'(src) + 17'(d) * 17'(inv);
			return acc[15:8];
		endfunction

		function logic [31:0] blend(logic [31:0] dest, logic [7:0] cov, logic [31:0] color);
			logic [15:0] src_full;
			logic [16:0] acc;
			logic [7:0]  src;
			logic [7:0]  inv;
			logic [7:0]  out_a;
			src_full = 16'(cov) * (16'd255 - 16'(color[7:0]));
			src = src_full[15:8];
			inv = 8'd255 - src;
			acc = 17'(dest[31:24]) * 17'(inv);
			out_a = src + acc[15:8];
			return {out_a,
				mix_channel(color[31:24], dest[23:16], src, inv),
				mix_channel(color[23:16], dest[15:8], src, inv),
				mix_channel(color[15:8], dest[7:0], src, inv)};
		endfunction

		// Applies one accepted request to the mirror and queues any read result.
		function void note_request(logic [1:0] req, logic [11:0] x, logic [11:0] y,
				logic [7:0] cov, logic [31:0] color);
			int unsigned   idx;
			bit            hit;
			logic [31:0]   dest;
			pixel_result_t res;
			hit = locate(x, y, idx);
			dest = (hit && pixel_mirror.exists(idx)) ? pixel_mirror[idx] : 32'h0;
			case (req)
				REQ_BLEND: if (hit) pixel_mirror[idx] = blend(dest, cov, color);
				REQ_READ: begin
					res.pixel   = hit ? dest : 32'h0;
					res.outside = !hit;
					awaited_pixels.push_back(res);
				end
				REQ_CLEAR: if (hit) pixel_mirror[idx] = 32'h0;
				default: ;
			endcase
		endfunction

		function void check_pixel(logic [31:0] pixel, logic outside);
			pixel_result_t res;
			if (awaited_pixels.size() == 0) begin
				$display("%0t: unexpected result, pixel %h out_of_range %b", $time, pixel,
					outside);
				errors++;
				return;
			end
			res = awaited_pixels.pop_front();
			if (pixel !== res.pixel) begin
				$display("%0t: pixel_word expected %h actual %h", $time, res.pixel, pixel);
				errors++;
			end
			if (outside !== res.outside) begin
				$display("%0t: out_of_range expected %b actual %b", $time, res.outside, outside);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return awaited_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	// From bit 0: pos_x[11:0], pos_y[23:12], coverage[31:24], color_rgba[63:32].
	logic [63:0] s_tdata;
	// Bits 1:0: req_type.
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// Bits 31:0: pixel_word.
	logic [31:0] m_tdata;
	// Bit 0: out_of_range.
	logic [0:0]  m_tuser;

	canvas_scoreboard sb = new();
	bit               sender_quiet = 1'b0;
	bit               receiver_quiet = 1'b0;
	int unsigned      hold_request = 0;

	coverage_alpha_blend_canvas_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every accepted request updates the mirror.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[31:24],
				s_tdata[63:32]);
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel(m_tdata, m_tuser[0]);
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stalls, a quiet mode and a long hold-off on request.
	initial begin
		int unsigned busy_left;
		int unsigned stall_left;
		busy_left = 0;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				m_tready <= 1'b0;
				hold_request--;
			end else if (receiver_quiet) begin
				m_tready <= 1'b1;
			end else begin
				if (busy_left == 0 && stall_left == 0) begin
					busy_left = $urandom_range(1, 24);
					stall_left = gap_len();
				end
				if (busy_left > 0) begin
					m_tready <= 1'b1;
					busy_left--;
				end else begin
					m_tready <= 1'b0;
					stall_left--;
				end
			end
		end
	end

	// Offers one request and returns once the transfer has taken place; valid stays high.
	task automatic send_request(logic [1:0] req, logic [11:0] x, logic [11:0] y,
			logic [7:0] cov, logic [31:0] color);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {color, cov, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Holds the input idle for a number of cycles.
	task automatic idle_input(int unsigned cycles);
		if (cycles > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (cycles - 1)
				@(negedge clk);
		end
	endtask

	task automatic offer_request(logic [1:0] req, logic [11:0] x, logic [11:0] y,
			logic [7:0] cov, logic [31:0] color);
		send_request(req, x, y, cov, color);
		if (!sender_quiet)
			idle_input(gap_len());
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes the whole rectangle, with noise in the unused upper bits.
	task automatic set_canvas(logic [11:0] left, logic [11:0] top, logic [12:0] width,
			logic [12:0] height);
		logic [31:0] noise;
		noise = $urandom;
		write_reg(REG_LEFT, {noise[31:12], left});
		noise = $urandom;
		write_reg(REG_TOP, {noise[31:12], top});
		noise = $urandom;
		write_reg(REG_WIDTH, {noise[31:13], width});
		noise = $urandom;
		write_reg(REG_HEIGHT, {noise[31:13], height});
	endtask

	// Waits until every read has returned and any blend in flight has finished.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Chooses a position: mostly near the canvas origin, some just outside the edges, some anywhere.
	task automatic pick_position(output logic [11:0] px, output logic [11:0] py);
		int unsigned r;
		int unsigned xs;
		int unsigned ys;
		r = $urandom_range(0, 99);
		xs = (sb.canvas_cfg.width > 48) ? 48 : sb.canvas_cfg.width;
		ys = (sb.canvas_cfg.height > 160) ? 160 : sb.canvas_cfg.height;
		px = sb.canvas_cfg.left + 12'($urandom_range(0, (xs == 0) ? 0 : xs - 1));
		py = sb.canvas_cfg.top + 12'($urandom_range(0, (ys == 0) ? 0 : ys - 1));
		if (r >= 70 && r < 78) begin
			px = $urandom_range(0, 1) ? sb.canvas_cfg.left - 12'd1 :
				12'(sb.canvas_cfg.left + sb.canvas_cfg.width);
		end else if (r >= 78 && r < 86) begin
			py = $urandom_range(0, 1) ? sb.canvas_cfg.top - 12'd1 :
				12'(sb.canvas_cfg.top + sb.canvas_cfg.height);
		end else if (r >= 86) begin
			px = 12'($urandom);
			py = 12'($urandom);
		end
	endtask

	task automatic random_request(output logic [1:0] req);
		int unsigned r;
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  cov;
		logic [31:0] color;
		r = $urandom_range(0, 99);
		req = (r < 45) ? REQ_BLEND : (r < 80) ? REQ_READ : (r < 93) ? REQ_CLEAR : REQ_UNUSED;
		pick_position(px, py);
		r = $urandom_range(0, 99);
		cov = (r < 15) ? 8'h00 : (r < 30) ? 8'hff : 8'($urandom);
		color = $urandom;
		r = $urandom_range(0, 99);
		if (r < 15)
			color[7:0] = 8'h00;
		else if (r < 30)
			color[7:0] = 8'hff;
		offer_request(req, px, py, cov, color);
	endtask

	// One random phase; ignored request codes do not count towards its length.
	task automatic run_random_phase(int unsigned phase);
		int unsigned counted;
		logic [1:0]  req;
		logic [11:0] px;
		logic [11:0] py;
		counted = 0;
		case (phase)
			1: set_canvas(12'd0, 12'd0, 13'd4096, 13'd4096);
			4: set_canvas(12'd4095, 12'd4095, 13'd4096, 13'd4096);
			5: set_canvas(12'($urandom), 12'($urandom), 13'($urandom_range(1, 4096)),
				13'($urandom_range(1, 4096)));
			6: set_canvas(12'($urandom), 12'($urandom), 13'd1, 13'($urandom_range(1, 4096)));
			default: set_canvas(12'($urandom), 12'($urandom), 13'($urandom_range(1, 16)),
				13'($urandom_range(1, 16)));
		endcase
		sender_quiet   = (phase == 2);
		receiver_quiet = (phase == 2);
		// Back the pipeline up: the receiver holds off while reads keep arriving.
		if (phase == 3) begin
			hold_request = HOLD_CYCLES;
			sender_quiet = 1'b1;
			repeat (40) begin
				pick_position(px, py);
				offer_request(REQ_READ, px, py, 8'($urandom), $urandom);
				counted++;
			end
			sender_quiet = 1'b0;
		end
		while (counted < PHASE_ITEMS) begin
			random_request(req);
			if (req != REQ_UNUSED)
				counted++;
		end
		settle();
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	// Main sequence: reset, directed checks, then random phases.
	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_BLEND;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single-pixel canvas after reset: the cleared pixel, blend, edges and clear.
		offer_request(REQ_READ, 12'd0, 12'd0, 8'h00, 32'h0);
		offer_request(REQ_BLEND, 12'd0, 12'd0, 8'hff, 32'hffffff00);
		offer_request(REQ_READ, 12'd0, 12'd0, 8'h00, 32'h0);
		offer_request(REQ_READ, 12'd1, 12'd0, 8'h00, 32'h0);
		offer_request(REQ_CLEAR, 12'd0, 12'd0, 8'h00, 32'h0);
		offer_request(REQ_READ, 12'd0, 12'd0, 8'h00, 32'h0);
		settle();

		// Small rectangle: corners, the left, right and top edges just outside, opaque and transparent sources.
		set_canvas(12'd10, 12'd20, 13'd4, 13'd3);
		offer_request(REQ_BLEND, 12'd10, 12'd20, 8'hff, 32'h12345600);
		offer_request(REQ_BLEND, 12'd13, 12'd22, 8'h80, 32'hff00ff7f);
		offer_request(REQ_UNUSED, 12'd13, 12'd22, 8'hff, 32'hffffffff);
		offer_request(REQ_READ, 12'd13, 12'd22, 8'h00, 32'h0);
		offer_request(REQ_READ, 12'd9, 12'd20, 8'h00, 32'h0);
		offer_request(REQ_READ, 12'd14, 12'd20, 8'h00, 32'h0);
		offer_request(REQ_READ, 12'd10, 12'd19, 8'h00, 32'h0);
		offer_request(REQ_BLEND, 12'd10, 12'd20, 8'hff, 32'hffffffff);
		offer_request(REQ_READ, 12'd10, 12'd20, 8'h00, 32'h0);
		settle();

		// Empty rectangle: zero width, then zero height.
		set_canvas(12'd10, 12'd20, 13'd0, 13'd3);
		offer_request(REQ_BLEND, 12'd10, 12'd20, 8'hff, 32'h0);
		offer_request(REQ_READ, 12'd10, 12'd20, 8'h00, 32'h0);
		settle();
		set_canvas(12'd10, 12'd20, 13'd4, 13'd0);
		offer_request(REQ_READ, 12'd10, 12'd20, 8'h00, 32'h0);
		settle();

		// Full coordinate space: the last store word and the first row beyond the store.
		set_canvas(12'd0, 12'd0, 13'd4096, 13'd4096);
		offer_request(REQ_BLEND, 12'd4095, 12'd127, 8'hff, 32'habcdef00);
		offer_request(REQ_READ, 12'd4095, 12'd127, 8'h00, 32'h0);
		offer_request(REQ_BLEND, 12'd0, 12'd128, 8'hff, 32'h0);
		offer_request(REQ_READ, 12'd0, 12'd128, 8'h00, 32'h0);
		settle();

		// Rectangle at the far corner.
		set_canvas(12'd4095, 12'd4095, 13'd1, 13'd1);
		offer_request(REQ_READ, 12'd4095, 12'd4095, 8'h00, 32'h0);
		offer_request(REQ_BLEND, 12'd4095, 12'd4095, 8'h7f, 32'h00ff0000);
		offer_request(REQ_READ, 12'd4095, 12'd4095, 8'h00, 32'h0);
		offer_request(REQ_READ, 12'd0, 12'd0, 8'h00, 32'h0);
		settle();

		for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
			run_random_phase(phase);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[coverage_alpha_blend_canvas_core] OK");
		else
			$display("[coverage_alpha_blend_canvas_core] ERROR");
		$finish;
	end

	// Overall time limit, well beyond the clearing pass and the slowest correct run.
	initial begin
		#20000000;
		$display("[coverage_alpha_blend_canvas_core] ERROR");
		$finish;
	end

endmodule
